FILE: sv/sart_pkg.sv
// Shared types and constants for the selective-ack receiver tracker.
// Holds field widths, the seen-map geometry, status codes, controller states
// and the command/status structs between controller and datapath.
package sart_pkg;

    // Header field widths
    localparam int SIZE_W  = 12;
    localparam int SEQ_W   = 12;
    localparam int LEN_W   = 24;
    localparam int FINAL_W = SEQ_W + 1;

    // Field positions in the header word
    localparam int SIZE_LSB = 20;
    localparam int SEQ_LSB  = 8;
    localparam int NAME_BIT = 1;

    // Sequence slots (power of two) and bytes per block (power of two)
    localparam int SEQ_SLOTS   = 4096;
    localparam int BLOCK_BYTES = 2048;
    localparam int BB_SHIFT    = $clog2(BLOCK_BYTES);
    localparam int SLOT_W      = $clog2(SEQ_SLOTS);

    // Seen-map organized as rows of ROW_W bits
    localparam int ROW_W  = (SEQ_SLOTS < 32) ? SEQ_SLOTS : 32;
    localparam int BIT_W  = $clog2(ROW_W);
    localparam int ROWS   = SEQ_SLOTS / ROW_W;
    localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;

    // Per-packet result codes
    typedef enum logic [1:0] {
        STAT_CORRUPT = 2'd0,
        STAT_NEW     = 2'd1,
        STAT_DUP     = 2'd2,
        STAT_IGNORED = 2'd3
    } status_t;

    // Controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_MARK,
        S_SCAN_RD,
        S_SCAN_TEST,
        S_EMIT
    } ctrl_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic    capture;
        logic    rd_item;
        logic    mark;
        logic    set_status;
        status_t status_code;
        logic    scan_start;
        logic    rd_scan;
        logic    scan_next;
        logic    set_finished;
        logic    load_out;
        logic    clear_step;
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic finished;
        logic corrupt;
        logic bit_seen;
        logic name_after;
        logic row_ok;
        logic scan_last;
        logic out_free;
        logic clear_last;
    } dp_stat_t;

endpackage

FILE: sv/sart_ctrl.sv
// Controller state machine for the selective-ack receiver tracker.
// Depends on sart_pkg for states and the command/status structs.
module sart_ctrl
    import sart_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.finished || stat.corrupt)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_MARK;
                end
            end
            S_MARK:
            begin
                if (stat.name_after)
                begin
                    state_next = S_SCAN_RD;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_TEST;
            end
            S_SCAN_TEST:
            begin
                if (!stat.row_ok || stat.scan_last)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // Drive commands
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
            end
            S_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
            end
            S_CHECK:
            begin
                if (stat.finished)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = STAT_IGNORED;
                end
                else if (stat.corrupt)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = STAT_CORRUPT;
                end
                else
                begin
                    cmd.rd_item = 1'b1;
                end
            end
            S_MARK:
            begin
                cmd.mark        = 1'b1;
                cmd.set_status  = 1'b1;
                cmd.status_code = stat.bit_seen ? STAT_DUP : STAT_NEW;
                cmd.scan_start  = stat.name_after;
            end
            S_SCAN_RD:
            begin
                cmd.rd_scan = 1'b1;
            end
            S_SCAN_TEST:
            begin
                if (stat.row_ok)
                begin
                    if (stat.scan_last)
                    begin
                        cmd.set_finished = 1'b1;
                    end
                    else
                    begin
                        cmd.scan_next = 1'b1;
                    end
                end
            end
            S_EMIT:
            begin
                cmd.load_out = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: sv/sart_dpath.sv
// Datapath for the selective-ack receiver tracker: item registers, seen-map
// memory, tracking state, completion scan and the output register.
// Depends on sart_pkg; driven by sart_ctrl through dp_cmd_t.
module sart_dpath
    import sart_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  dp_cmd_t             cmd,
    output dp_stat_t            stat,
    input  logic [31:0]         header_word,
    input  logic                digest_ok,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          status,
    output logic                ack_valid,
    output logic [SEQ_W-1:0]    ack_number,
    output logic                done_res,
    output logic [FINAL_W-1:0]  final_ack,
    output logic [LEN_W-1:0]    file_length
);

    // Captured item
    logic [SIZE_W-1:0] size_reg;
    logic [SEQ_W-1:0]  seq_reg;
    logic              is_name_reg;
    logic              dok_reg;

    // Tracking state
    logic              name_seen_reg;
    logic [SEQ_W-1:0]  last_seq_reg;
    logic [LEN_W-1:0]  length_reg;
    logic              finished_reg;
    status_t           res_status_reg;

    // Sweep pointers
    logic [ROW_AW-1:0] clr_ptr_reg;
    logic [ROW_AW-1:0] scan_ptr_reg;

    // Seen-map memory
    logic [ROW_W-1:0]  seen_mem [ROWS];
    logic [ROW_W-1:0]  rdata_reg;
    logic              mem_we;
    logic [ROW_AW-1:0] mem_waddr;
    logic [ROW_W-1:0]  mem_wdata;
    logic              mem_re;
    logic [ROW_AW-1:0] mem_raddr;

    // Output register
    logic               out_valid_reg;
    status_t            out_status_reg;
    logic               out_ack_valid_reg;
    logic [SEQ_W-1:0]   out_ack_num_reg;
    logic               out_done_reg;
    logic [FINAL_W-1:0] out_final_reg;
    logic [LEN_W-1:0]   out_len_reg;

    // Derived values
    logic [SLOT_W-1:0]  item_slot;
    logic [ROW_AW-1:0]  item_row;
    logic [BIT_W-1:0]   item_bit;
    logic               bit_seen;
    logic               mark_new;
    logic [ROW_W-1:0]   row_set;
    logic [LEN_W-1:0]   end_len;
    logic [SLOT_W-1:0]  limit_slot;
    logic [ROW_AW-1:0]  limit_row;
    logic [BIT_W-1:0]   limit_bit;
    logic [ROW_W-1:0]   row_mask;
    logic               resp_ack;

    // Decode slot and row
    assign item_slot = seq_reg[SLOT_W-1:0];
    assign item_row  = ROW_AW'(item_slot >> BIT_W);
    assign item_bit  = item_slot[BIT_W-1:0];
    assign bit_seen  = rdata_reg[item_bit];
    assign mark_new  = cmd.mark && !bit_seen;
    assign end_len   = (LEN_W'(seq_reg) << BB_SHIFT) + LEN_W'(size_reg);

    always_comb
    begin
        row_set           = rdata_reg;
        row_set[item_bit] = 1'b1;
    end

    // Bound the completion scan to the last slot in the map
    always_comb
    begin
        if ({1'b0, last_seq_reg} >= (SEQ_W + 1)'(SEQ_SLOTS))
        begin
            limit_slot = SLOT_W'(SEQ_SLOTS - 1);
        end
        else
        begin
            limit_slot = last_seq_reg[SLOT_W-1:0];
        end
    end

    assign limit_row = ROW_AW'(limit_slot >> BIT_W);
    assign limit_bit = limit_slot[BIT_W-1:0];

    // Mask off bits beyond the last slot on the final row
    always_comb
    begin
        for (int i = 0; i < ROW_W; i++)
        begin
            row_mask[i] = (scan_ptr_reg != limit_row) || (BIT_W'(i) <= limit_bit);
        end
    end

    // Memory port select
    always_comb
    begin
        mem_we    = cmd.clear_step || mark_new;
        mem_waddr = cmd.clear_step ? clr_ptr_reg : item_row;
        mem_wdata = cmd.clear_step ? '0 : row_set;
        mem_re    = cmd.rd_item || cmd.rd_scan;
        mem_raddr = cmd.rd_scan ? scan_ptr_reg : item_row;
    end

    // Seen-map storage with registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            seen_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= seen_mem[mem_raddr];
        end
    end

    // Capture the header fields on transfer
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            size_reg    <= header_word[SIZE_LSB +: SIZE_W];
            seq_reg     <= header_word[SEQ_LSB +: SEQ_W];
            is_name_reg <= header_word[NAME_BIT];
            dok_reg     <= digest_ok;
        end
        if (cmd.set_status)
        begin
            res_status_reg <= cmd.status_code;
        end
    end

    // Update tracking state and sweep pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            name_seen_reg <= 1'b0;
            last_seq_reg  <= '0;
            length_reg    <= '0;
            finished_reg  <= 1'b0;
            clr_ptr_reg   <= '0;
            scan_ptr_reg  <= '0;
        end
        else
        begin
            if (mark_new)
            begin
                if (is_name_reg)
                begin
                    name_seen_reg <= 1'b1;
                    last_seq_reg  <= seq_reg;
                end
                else if (end_len > length_reg)
                begin
                    length_reg <= end_len;
                end
            end
            if (cmd.set_finished)
            begin
                finished_reg <= 1'b1;
            end
            if (cmd.clear_step)
            begin
                clr_ptr_reg <= ROW_AW'(clr_ptr_reg + 1'b1);
            end
            if (cmd.scan_start)
            begin
                scan_ptr_reg <= '0;
            end
            else if (cmd.scan_next)
            begin
                scan_ptr_reg <= ROW_AW'(scan_ptr_reg + 1'b1);
            end
        end
    end

    // Hold the result until the transfer completes
    assign resp_ack = (res_status_reg == STAT_NEW) || (res_status_reg == STAT_DUP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_status_reg    <= res_status_reg;
            out_ack_valid_reg <= resp_ack;
            out_ack_num_reg   <= resp_ack ? seq_reg : '0;
            out_done_reg      <= finished_reg;
            out_final_reg     <= finished_reg ? ({1'b0, last_seq_reg} + FINAL_W'(1)) : '0;
            out_len_reg       <= length_reg;
        end
    end

    // Report status to the controller
    always_comb
    begin
        stat.finished   = finished_reg;
        stat.corrupt    = (size_reg > SIZE_W'(BLOCK_BYTES)) || !dok_reg;
        stat.bit_seen   = bit_seen;
        stat.name_after = name_seen_reg || (is_name_reg && !bit_seen);
        stat.row_ok     = &(rdata_reg | ~row_mask);
        stat.scan_last  = (scan_ptr_reg == limit_row);
        stat.out_free   = !out_valid_reg || !out_stall;
        stat.clear_last = (clr_ptr_reg == ROW_AW'(ROWS - 1));
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign ack_valid   = out_ack_valid_reg;
    assign ack_number  = out_ack_num_reg;
    assign done_res    = out_done_reg;
    assign final_ack   = out_final_reg;
    assign file_length = out_len_reg;

    // Completion is sticky
    a_fin_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg |=> finished_reg)
        else $error("finished flag dropped");

    // File length never shrinks
    a_len_mono: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (length_reg >= $past(length_reg)))
        else $error("file length decreased");

    // Completion only after the name packet
    a_fin_name: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.set_finished |-> name_seen_reg)
        else $error("done without name packet");

    // Never overwrite a result still waiting
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || !out_stall))
        else $error("result overwritten while stalled");

    // Seen-map is frozen once done
    a_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg |-> !mem_we)
        else $error("seen-map written after done");

endmodule

FILE: sv/selective_ack_receiver_tracker_core.sv
// Selective-ack receiver tracker, top level: controller plus datapath.
// Depends on sart_pkg, sart_ctrl and sart_dpath.
//
// Takes one packet header and digest flag per transfer and returns one result
// per packet. After reset the seen-map is swept clear, one 32-slot row per
// cycle, while in_stall stays high. An ignored or corrupt packet passes from
// idle through check to emit; a valid packet also passes through mark. Once
// the name packet is known each valid packet also rescans the seen-map from
// row 0 up to the row of the last sequence, stopping at the first row with a
// gap, reading and then testing each row through the single read port. The
// result register frees the input side: the next packet is taken while the
// previous result waits.
module selective_ack_receiver_tracker_core
    import sart_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [31:0]         header_word,
    input  logic                digest_ok,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          status,
    output logic                ack_valid,
    output logic [SEQ_W-1:0]    ack_number,
    output logic                done_res,
    output logic [FINAL_W-1:0]  final_ack,
    output logic [LEN_W-1:0]    file_length
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequence the packet work
    sart_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Hold state, seen-map and result
    sart_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .header_word (header_word),
        .digest_ok   (digest_ok),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .ack_valid   (ack_valid),
        .ack_number  (ack_number),
        .done_res    (done_res),
        .final_ack   (final_ack),
        .file_length (file_length)
    );

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// Testbench for selective_ack_receiver_tracker_core: drives packet headers,
// predicts each result with its own tracker model and checks every field.
// Depends on sart_pkg and the core RTL; reads no files.
module tb;
    import sart_pkg::*;

    // Sequence held back until the end so that the transfer cannot finish early
    localparam int GAP_SEQ      = 40;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 300;
    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int MAX_REPORTS  = 40;

    typedef struct {
        status_t              status;
        logic                 ack_valid;
        logic [SEQ_W-1:0]     ack_number;
        logic                 done_res;
        logic [FINAL_W-1:0]   final_ack;
        logic [LEN_W-1:0]     file_length;
    } pkt_result_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [31:0]         header_word;
    logic                digest_ok;
    logic                out_valid;
    logic                out_stall;
    logic [1:0]          status;
    logic                ack_valid;
    logic [SEQ_W-1:0]    ack_number;
    logic                done_res;
    logic [FINAL_W-1:0]  final_ack;
    logic [LEN_W-1:0]    file_length;

    // Tracker state mirrored by the testbench
    bit                  seen_bits [SEQ_SLOTS];
    bit                  trk_name_seen = 1'b0;
    logic [SEQ_W-1:0]    trk_last = '0;
    logic [LEN_W-1:0]    trk_length = '0;
    bit                  trk_finished = 1'b0;

    pkt_result_t         queued_results [$];
    pkt_result_t         want_r;
    int                  mismatches = 0;
    int                  results_checked = 0;
    int                  packets_sent = 0;
    int                  stat_count [4];
    int                  cycle_count = 0;
    bit                  idle_on = 1'b1;
    bit                  hold_req = 1'b0;

    selective_ack_receiver_tracker_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .header_word (header_word),
        .digest_ok   (digest_ok),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .ack_valid   (ack_valid),
        .ack_number  (ack_number),
        .done_res    (done_res),
        .final_ack   (final_ack),
        .file_length (file_length)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Check whether every sequence from zero through the last one was seen
    function automatic bit all_slots_seen();
        for (int i = 0; i <= int'(trk_last); i++)
        begin
            if (!seen_bits[i % SEQ_SLOTS])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Advance the tracker by one packet and return the result it implies
    function automatic pkt_result_t track_packet(input logic [31:0] hdr, input logic dok);
        pkt_result_t       r;
        logic [SIZE_W-1:0] sz;
        logic [SEQ_W-1:0]  seq;
        logic [31:0]       reach;
        r.status      = STAT_CORRUPT;
        r.ack_valid   = 1'b0;
        r.ack_number  = '0;
        sz  = hdr[SIZE_LSB +: SIZE_W];
        seq = hdr[SEQ_LSB +: SEQ_W];
        if (trk_finished)
        begin
            r.status = STAT_IGNORED;
        end
        else if (int'(sz) <= BLOCK_BYTES && dok)
        begin
            if (!seen_bits[int'(seq) % SEQ_SLOTS])
            begin
                r.status = STAT_NEW;
                if (hdr[NAME_BIT])
                begin
                    trk_name_seen = 1'b1;
                    trk_last      = seq;
                end
                else
                begin
                    reach = (32'(seq) * BLOCK_BYTES + 32'(sz)) & 32'h00FF_FFFF;
                    if (reach[LEN_W-1:0] > trk_length)
                        trk_length = reach[LEN_W-1:0];
                end
                seen_bits[int'(seq) % SEQ_SLOTS] = 1'b1;
            end
            else
            begin
                r.status = STAT_DUP;
            end
            r.ack_valid  = 1'b1;
            r.ack_number = seq;
            if (trk_name_seen && all_slots_seen())
                trk_finished = 1'b1;
        end
        r.done_res    = trk_finished;
        r.final_ack   = trk_finished ? ({1'b0, trk_last} + 1'b1) : '0;
        r.file_length = trk_length;
        return r;
    endfunction

    function automatic logic [31:0] make_header(input int size, input int seq, input bit is_name);
        logic [31:0] hdr;
        hdr = $urandom;
        hdr[SIZE_LSB +: SIZE_W] = SIZE_W'(size);
        hdr[SEQ_LSB +: SEQ_W]   = SEQ_W'(seq);
        hdr[NAME_BIT]           = is_name;
        return hdr;
    endfunction

    // Well-formed packet that never touches the held-back sequence
    function automatic logic [31:0] pick_good_header();
        int size;
        int seq;
        bit is_name;
        case ($urandom_range(0, 9))
            0:       size = 0;
            1:       size = BLOCK_BYTES;
            default: size = $urandom_range(0, BLOCK_BYTES);
        endcase
        if ($urandom_range(0, 99) < 85)
            seq = $urandom_range(0, 511);
        else
            seq = $urandom_range(0, SEQ_SLOTS - 1);
        is_name = ($urandom_range(0, 99) < 8);
        if (is_name && seq <= GAP_SEQ)
            seq = GAP_SEQ + 1 + seq;
        if (seq == GAP_SEQ)
            seq = seq + 1;
        return make_header(size, seq, is_name);
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch at result %0d: %s got %0h want %0h",
                     results_checked, what, got, want);
    endtask

    // Offer one packet, hold it until the transfer, then record the prediction
    task automatic send_packet(input logic [31:0] hdr, input logic dok);
        int gap;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 19);
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    = 1'b1;
        header_word = hdr;
        digest_ok   = dok;
        do
            @(posedge clk);
        while (in_stall);
        queued_results.push_back(track_packet(hdr, dok));
        packets_sent++;
    endtask

    // Receiver: random stall bursts, plus one long hold-off on request
    initial
    begin
        int n;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req  = 1'b0;
                out_stall = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 19);
                out_stall = 1'b1;
                repeat (n) @(negedge clk);
                out_stall = 1'b0;
            end
        end
    end

    // Compare each result transfer with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (queued_results.size() == 0)
            begin
                report_mismatch("result with nothing pending", status, 0);
            end
            else
            begin
                want_r = queued_results.pop_front();
                if (status !== want_r.status)
                    report_mismatch("status", status, want_r.status);
                if (ack_valid !== want_r.ack_valid)
                    report_mismatch("ack_valid", ack_valid, want_r.ack_valid);
                if (ack_number !== want_r.ack_number)
                    report_mismatch("ack_number", ack_number, want_r.ack_number);
                if (done_res !== want_r.done_res)
                    report_mismatch("done_res", done_res, want_r.done_res);
                if (final_ack !== want_r.final_ack)
                    report_mismatch("final_ack", final_ack, want_r.final_ack);
                if (file_length !== want_r.file_length)
                    report_mismatch("file_length", file_length, want_r.file_length);
                stat_count[want_r.status]++;
                results_checked++;
            end
        end
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Field extremes, corrupt forms, duplicates and name packet handling
    task automatic test_directed();
        send_packet(make_header(0, 1, 1'b0), 1'b1);
        send_packet(make_header(BLOCK_BYTES, 2, 1'b0), 1'b1);
        send_packet(make_header(BLOCK_BYTES + 1, 3, 1'b0), 1'b1);
        send_packet(make_header(4095, 3, 1'b0), 1'b1);
        send_packet(make_header(5, 3, 1'b0), 1'b0);
        send_packet(make_header(100, 1, 1'b0), 1'b1);
        send_packet(32'hFFFF_FFFF, 1'b1);
        send_packet(32'hFFFF_FFFF, 1'b0);
        send_packet(32'h0000_0000, 1'b1);
        send_packet(32'h0000_0000, 1'b0);
        // name packets: new, duplicate, corrupt, then moving the last sequence
        send_packet(make_header(7, GAP_SEQ + 60, 1'b1), 1'b1);
        send_packet(make_header(7, GAP_SEQ + 60, 1'b1), 1'b1);
        send_packet(make_header(9, GAP_SEQ + 61, 1'b1), 1'b0);
        send_packet(make_header(0, 3000, 1'b1), 1'b1);
        send_packet(make_header(10, 50, 1'b1), 1'b1);
        send_packet(make_header(2047, 5, 1'b0), 1'b1);
        send_packet(make_header(3, 50, 1'b0), 1'b1);
        send_packet({12'd1, 12'd6, 8'hFD}, 1'b1);
        send_packet({12'd1, 12'd7, 8'h00}, 1'b1);
    endtask

    // Mostly well-formed packets, some broken ones and raw noise
    task automatic test_random(input int count);
        logic [31:0] hdr;
        logic        dok;
        int          pick;
        for (int k = 0; k < count; k++)
        begin
            if (k % 100 == 0)
                idle_on = ($urandom_range(0, 2) != 0);
            pick = $urandom_range(0, 99);
            if (pick < 72)
            begin
                hdr = pick_good_header();
                dok = 1'b1;
            end
            else if (pick < 85)
            begin
                hdr = pick_good_header();
                dok = 1'b1;
                if ($urandom_range(0, 1))
                    dok = 1'b0;
                else
                    hdr[SIZE_LSB +: SIZE_W] = SIZE_W'($urandom_range(BLOCK_BYTES + 1, 4095));
            end
            else
            begin
                hdr = $urandom;
                dok = 1'($urandom_range(0, 1));
            end
            // drop anything that would close the held-back sequence
            if (int'(hdr[SIZE_LSB +: SIZE_W]) <= BLOCK_BYTES && dok
                && (int'(hdr[SEQ_LSB +: SEQ_W]) == GAP_SEQ
                    || (hdr[NAME_BIT] && int'(hdr[SEQ_LSB +: SEQ_W]) <= GAP_SEQ)))
                dok = 1'b0;
            send_packet(hdr, dok);
        end
        idle_on = 1'b1;
    endtask

    // Hold the receiver off while packets keep coming, so the input stalls
    task automatic test_backpressure();
        idle_on  = 1'b0;
        hold_req = 1'b1;
        repeat (20) send_packet(pick_good_header(), 1'b1);
        idle_on  = 1'b1;
    endtask

    // Pause the sender until every pending result has come back
    task automatic test_drain();
        repeat (10) send_packet(pick_good_header(), 1'b1);
        @(negedge clk);
        in_valid = 1'b0;
        while (queued_results.size() != 0)
            @(posedge clk);
    endtask

    // Largest file length, then a block that must not shrink it
    task automatic test_length_extremes();
        send_packet(make_header(BLOCK_BYTES, SEQ_SLOTS - 1, 1'b0), 1'b1);
        send_packet(make_header(0, SEQ_SLOTS - 2, 1'b0), 1'b1);
    endtask

    // Close every open sequence up to the last, then confirm items are ignored
    task automatic test_completion();
        int s;
        idle_on = 1'b0;
        s = -1;
        for (int i = GAP_SEQ + 1; i < SEQ_SLOTS; i++)
        begin
            if (!seen_bits[i])
            begin
                s = i;
                break;
            end
        end
        if (s >= 0)
            send_packet(make_header($urandom_range(0, BLOCK_BYTES), s, 1'b1), 1'b1);
        for (int i = 0; i <= int'(trk_last); i++)
        begin
            if (!seen_bits[i])
                send_packet(make_header($urandom_range(0, BLOCK_BYTES), i, 1'b0), 1'b1);
        end
        repeat (10) send_packet(pick_good_header(), 1'b1);
        repeat (10) send_packet($urandom, 1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        header_word = '0;
        digest_ok   = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random(540);
        test_backpressure();
        test_drain();
        test_random(540);
        test_length_extremes();
        test_completion();

        @(negedge clk);
        in_valid = 1'b0;
        while (queued_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (queued_results.size() != 0)
            report_mismatch("expectations left over", queued_results.size(), 0);

        $display("covered %0d packets: %0d new, %0d duplicate, %0d corrupt, %0d after done",
                 packets_sent, stat_count[STAT_NEW], stat_count[STAT_DUP],
                 stat_count[STAT_CORRUPT], stat_count[STAT_IGNORED]);
        $display("completion reached: %0d, final ack %0d, %0d mismatches",
                 trk_finished, {1'b0, trk_last} + 1, mismatches);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
